// File: design/dqdp_pkg.sv
// dqdp_pkg: widths, command struct and codes for the dequantized dot product core
// standalone, no dependencies
package dqdp_pkg;

	// item and result field widths
	localparam int CODE_W     = 8;
	localparam int Q_W        = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// longest dot product in normal use
	localparam int MAX_LEN    = 256;

	// running sums
	localparam int PSUM_W     = 48;
	localparam int ASUM_W     = 40;
	localparam int ITEM_W     = CODE_W + 1 + Q_W;

	// shared finishing multiplier, split points of the sums
	localparam int PS_SPLIT   = 24;
	localparam int AS_SPLIT   = 20;
	localparam int MUL_A_W    = PS_SPLIT + 1;
	localparam int MUL_B_W    = Q_W + 1;
	localparam int MUL_W      = MUL_A_W + MUL_B_W;
	localparam int PACC_W     = MUL_W + PS_SPLIT;
	localparam int QACC_W     = MUL_W + AS_SPLIT;
	localparam int SCALE_SH   = 16;
	localparam int FRAC_SH    = 12;
	localparam int TOTAL_W    = PACC_W - SCALE_SH;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

	// multiplier operand selects
	localparam logic [1:0] MUL_PS_LO = 2'd0;
	localparam logic [1:0] MUL_PS_HI = 2'd1;
	localparam logic [1:0] MUL_AS_LO = 2'd2;
	localparam logic [1:0] MUL_AS_HI = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic       accum;
		logic       snap;
		logic [1:0] mul_sel;
		logic       p_load;
		logic       p_add;
		logic       q_load;
		logic       q_add;
		logic       sum;
		logic       out_load;
	} cmd_t;

endpackage

// File: design/dqdp_if.sv
// dqdp channel interfaces: input items, result items, register writes
// depends on dqdp_pkg
interface dqdp_in_if;
	logic                              valid;
	logic                              ready;
	logic        [dqdp_pkg::CODE_W-1:0] weight_code;
	logic signed [dqdp_pkg::Q_W-1:0]    activation;
	logic                              last;

	modport source(output valid, output weight_code, output activation, output last,
		input ready);
	modport sink(input valid, input weight_code, input activation, input last,
		output ready);
endinterface

interface dqdp_out_if;
	logic                           valid;
	logic                           ready;
	logic signed [dqdp_pkg::Q_W-1:0] value;
	logic                           saturated;

	modport source(output valid, output value, output saturated, input ready);
	modport sink(input valid, input value, input saturated, output ready);
endinterface

interface dqdp_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [dqdp_pkg::CFG_IDX_W-1:0]      index;
	logic [dqdp_pkg::CFG_DATA_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: design/dqdp_ctrl.sv
// dqdp_ctrl: sequencer for accumulate, finishing multiply steps and result handoff
// depends on dqdp_pkg
module dqdp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_last,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	output dqdp_pkg::cmd_t      cmd
);

	localparam logic [2:0] ST_ACC = 3'd0;
	localparam logic [2:0] ST_M0  = 3'd1;
	localparam logic [2:0] ST_M1  = 3'd2;
	localparam logic [2:0] ST_M2  = 3'd3;
	localparam logic [2:0] ST_M3  = 3'd4;
	localparam logic [2:0] ST_M4  = 3'd5;
	localparam logic [2:0] ST_SUM = 3'd6;
	localparam logic [2:0] ST_OUT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       in_fire;

	assign in_ready  = (state_q == ST_ACC);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_ACC: begin
				cmd.accum = in_fire;
				cmd.snap  = in_fire && in_last;
				if (in_fire && in_last) begin
					state_d = ST_M0;
				end
			end
			ST_M0: begin
				cmd.mul_sel = dqdp_pkg::MUL_PS_LO;
				state_d     = ST_M1;
			end
			ST_M1: begin
				cmd.mul_sel = dqdp_pkg::MUL_PS_HI;
				cmd.p_load  = 1'b1;
				state_d     = ST_M2;
			end
			ST_M2: begin
				cmd.mul_sel = dqdp_pkg::MUL_AS_LO;
				cmd.p_add   = 1'b1;
				state_d     = ST_M3;
			end
			ST_M3: begin
				cmd.mul_sel = dqdp_pkg::MUL_AS_HI;
				cmd.q_load  = 1'b1;
				state_d     = ST_M4;
			end
			ST_M4: begin
				cmd.q_add = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_ACC;
				end
			end
			default: state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/dqdp_datapath.sv
// dqdp_datapath: config registers, running sums, shared finishing multiplier,
// saturation and result register; depends on dqdp_pkg
module dqdp_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dqdp_pkg::cmd_t                       cmd,
	input  logic        [dqdp_pkg::CODE_W-1:0]   weight_code,
	input  logic signed [dqdp_pkg::Q_W-1:0]      activation,
	input  logic                                 cfg_we,
	input  logic        [dqdp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [dqdp_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic signed [dqdp_pkg::Q_W-1:0]      value,
	output logic                                 saturated
);

	localparam int PSUM_W  = dqdp_pkg::PSUM_W;
	localparam int ASUM_W  = dqdp_pkg::ASUM_W;
	localparam int ITEM_W  = dqdp_pkg::ITEM_W;
	localparam int Q_W     = dqdp_pkg::Q_W;
	localparam int MUL_A_W = dqdp_pkg::MUL_A_W;
	localparam int MUL_B_W = dqdp_pkg::MUL_B_W;
	localparam int MUL_W   = dqdp_pkg::MUL_W;
	localparam int PACC_W  = dqdp_pkg::PACC_W;
	localparam int QACC_W  = dqdp_pkg::QACC_W;
	localparam int TOTAL_W = dqdp_pkg::TOTAL_W;
	localparam int PS_SP   = dqdp_pkg::PS_SPLIT;
	localparam int AS_SP   = dqdp_pkg::AS_SPLIT;

	logic        [Q_W-1:0]     scale_q;
	logic signed [Q_W-1:0]     offset_q;
	logic                      mode_q;

	logic signed [PSUM_W-1:0]  psum_q;
	logic signed [ASUM_W-1:0]  asum_q;
	logic signed [PSUM_W-1:0]  ps_snap_q;
	logic signed [ASUM_W-1:0]  as_snap_q;

	logic signed [ITEM_W-1:0]  item_prod;
	logic signed [PSUM_W-1:0]  psum_next;
	logic signed [ASUM_W-1:0]  asum_next;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_W-1:0]   mul_s1;

	logic signed [PACC_W-1:0]  pacc_q;
	logic signed [QACC_W-1:0]  qacc_q;
	logic signed [TOTAL_W-1:0] total_q;
	logic signed [TOTAL_W-1:0] term_p;
	logic signed [TOTAL_W-1:0] term_q;
	logic                      in_range;
	logic signed [Q_W-1:0]     value_q;
	logic                      sat_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= '0;
			offset_q <= '0;
			mode_q   <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == dqdp_pkg::REG_SCALE) begin
				scale_q <= cfg_data[Q_W-1:0];
			end else if (cfg_index == dqdp_pkg::REG_OFFSET) begin
				offset_q <= cfg_data[Q_W-1:0];
			end else if (cfg_index == dqdp_pkg::REG_MODE) begin
				mode_q <= cfg_data[0];
			end
		end
	end

	// per item multiply-accumulate
	assign item_prod = $signed({1'b0, weight_code}) * activation;
	assign psum_next = psum_q + {{(PSUM_W-ITEM_W){item_prod[ITEM_W-1]}}, item_prod};
	assign asum_next = asum_q + {{(ASUM_W-Q_W){activation[Q_W-1]}}, activation};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
			asum_q <= '0;
		end else if (cmd.accum) begin
			if (cmd.snap) begin
				psum_q <= '0;
				asum_q <= '0;
			end else begin
				psum_q <= psum_next;
				asum_q <= asum_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			ps_snap_q <= psum_next;
			as_snap_q <= asum_next;
		end
	end

	// shared multiplier, one partial product per cycle
	always_comb begin
		unique case (cmd.mul_sel)
			dqdp_pkg::MUL_PS_LO: begin
				mul_a = {1'b0, ps_snap_q[PS_SP-1:0]};
				mul_b = {1'b0, scale_q};
			end
			dqdp_pkg::MUL_PS_HI: begin
				mul_a = {ps_snap_q[PSUM_W-1], ps_snap_q[PSUM_W-1:PS_SP]};
				mul_b = {1'b0, scale_q};
			end
			dqdp_pkg::MUL_AS_LO: begin
				mul_a = {{(MUL_A_W-AS_SP){1'b0}}, as_snap_q[AS_SP-1:0]};
				mul_b = {offset_q[Q_W-1], offset_q};
			end
			dqdp_pkg::MUL_AS_HI: begin
				mul_a = {{(MUL_A_W-(ASUM_W-AS_SP)){as_snap_q[ASUM_W-1]}},
					as_snap_q[ASUM_W-1:AS_SP]};
				mul_b = {offset_q[Q_W-1], offset_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_s1 <= mul_a * mul_b;
	end

	// partial product accumulation
	always_ff @(posedge clk) begin
		if (cmd.p_load) begin
			pacc_q <= {{(PACC_W-MUL_W){mul_s1[MUL_W-1]}}, mul_s1};
		end else if (cmd.p_add) begin
			pacc_q <= pacc_q + {mul_s1, {PS_SP{1'b0}}};
		end
		if (cmd.q_load) begin
			qacc_q <= {{(QACC_W-MUL_W){mul_s1[MUL_W-1]}}, mul_s1};
		end else if (cmd.q_add) begin
			qacc_q <= qacc_q + {mul_s1, {AS_SP{1'b0}}};
		end
	end

	// floor shifts are plain part-selects of the two's complement sums
	assign term_p = pacc_q[PACC_W-1:dqdp_pkg::SCALE_SH];
	assign term_q = mode_q
		? {{(TOTAL_W-(QACC_W-dqdp_pkg::FRAC_SH)){qacc_q[QACC_W-1]}},
			qacc_q[QACC_W-1:dqdp_pkg::FRAC_SH]}
		: {{(TOTAL_W-Q_W){offset_q[Q_W-1]}}, offset_q};

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			total_q <= term_p + term_q;
		end
	end

	// saturate to q4.12
	assign in_range = (&total_q[TOTAL_W-1:Q_W-1]) || !(|total_q[TOTAL_W-1:Q_W-1]);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sat_q <= !in_range;
			if (in_range) begin
				value_q <= total_q[Q_W-1:0];
			end else if (total_q[TOTAL_W-1]) begin
				value_q <= {1'b1, {(Q_W-1){1'b0}}};
			end else begin
				value_q <= {1'b0, {(Q_W-1){1'b1}}};
			end
		end
	end

	assign value     = value_q;
	assign saturated = sat_q;

endmodule

// File: design/dequantized_dot_product_core.sv
// dequantized_dot_product_core: an item without last is taken every cycle
// an item with last blocks the input until its result is loaded: it is accumulated, the
// shared 25x17 multiplier forms the low and high partial products of both sums, adds follow,
// then the result load, held while dout has the old result; the new one shows the cycle after
// reset (arst_n low) clears the sums, the registers scale, offset, mode and the handshakes
// depends on dqdp_pkg, dqdp_if, dqdp_ctrl, dqdp_datapath
module dequantized_dot_product_core (
	input  logic        clk,
	input  logic        arst_n,
	dqdp_in_if.sink     din,
	dqdp_out_if.source  dout,
	dqdp_cfg_if.sink    cfg
);

	dqdp_pkg::cmd_t cmd;
	logic           cfg_we;

	// register writes are always taken
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	// sequencer: accumulate state, multiply steps, result handoff
	dqdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_last   (din.last),
		.in_ready  (din.ready),
		.out_ready (dout.ready),
		.out_valid (dout.valid),
		.cmd       (cmd)
	);

	// sums, finishing arithmetic and the result register
	dqdp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.weight_code (din.weight_code),
		.activation  (din.activation),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.value       (dout.value),
		.saturated   (dout.saturated)
	);

endmodule

// File: tb/dqdp_checker.sv
// dqdp_checker: predicts every dot product entry from the accepted items and register
// writes, and compares each result item with the oldest prediction
// depends on dqdp_pkg and dqdp_if
module dqdp_checker (
	input  logic clk,
	input  logic arst_n,
	dqdp_in_if   din,
	dqdp_out_if  dout,
	dqdp_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDE_W = 72;
	localparam int REPORT_MAX = 10;
	localparam logic signed [WIDE_W-1:0] Q_HI = 32767;
	localparam logic signed [WIDE_W-1:0] Q_LO = -32768;

	typedef struct packed {
		logic signed [dqdp_pkg::Q_W-1:0] value;
		logic                            saturated;
	} entry_t;

	logic        [dqdp_pkg::Q_W-1:0]    scale_q;
	logic signed [dqdp_pkg::Q_W-1:0]    offset_q;
	logic                               mode_q;
	logic signed [dqdp_pkg::PSUM_W-1:0] dot_sum;
	logic signed [dqdp_pkg::ASUM_W-1:0] act_sum;
	entry_t                             entries_due[$];

	// scale the sums and add the offset term, then clip to q4.12
	function automatic entry_t dequantize(logic signed [dqdp_pkg::PSUM_W-1:0] ps,
		logic signed [dqdp_pkg::ASUM_W-1:0] as);
		logic signed [WIDE_W-1:0] wide;
		logic signed [WIDE_W-1:0] total;
		entry_t                   r;
		wide = ps * $signed({1'b0, scale_q});
		total = wide >>> dqdp_pkg::SCALE_SH;
		if (!mode_q) begin
			wide = offset_q;
		end else begin
			wide = offset_q * as;
			wide = wide >>> dqdp_pkg::FRAC_SH;
		end
		total = total + wide;
		r.saturated = 1'b1;
		if (total > Q_HI) begin
			r.value = Q_HI[dqdp_pkg::Q_W-1:0];
		end else if (total < Q_LO) begin
			r.value = Q_LO[dqdp_pkg::Q_W-1:0];
		end else begin
			r.value = total[dqdp_pkg::Q_W-1:0];
			r.saturated = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [dqdp_pkg::PSUM_W-1:0] ps_next;
		logic signed [dqdp_pkg::ASUM_W-1:0] as_next;
		entry_t                             want;
		if (!arst_n) begin
			scale_q = '0;
			offset_q = '0;
			mode_q = 1'b0;
			dot_sum = '0;
			act_sum = '0;
			entries_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (dout.valid && dout.ready) begin
				if (entries_due.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("checker: unexpected result value=%0d saturated=%0b",
							dout.value, dout.saturated);
					fail_count++;
				end else begin
					want = entries_due.pop_front();
					if (want.value !== dout.value || want.saturated !== dout.saturated) begin
						if (fail_count < REPORT_MAX)
							$display("checker: expected %0d/%0b, got %0d/%0b",
								want.value, want.saturated, dout.value, dout.saturated);
						fail_count++;
					end
				end
			end
			if (din.valid && din.ready) begin
				ps_next = dot_sum + $signed({1'b0, din.weight_code}) * din.activation;
				as_next = act_sum + din.activation;
				if (din.last) begin
					entries_due.push_back(dequantize(ps_next, as_next));
					dot_sum = '0;
					act_sum = '0;
				end else begin
					dot_sum = ps_next;
					act_sum = as_next;
				end
			end
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					dqdp_pkg::REG_SCALE: scale_q = cfg.data;
					dqdp_pkg::REG_OFFSET: offset_q = cfg.data;
					dqdp_pkg::REG_MODE: mode_q = cfg.data[0];
					default: ;
				endcase
			end
			pending = entries_due.size();
		end
	end

endmodule

// File: tb/tb_dequantized_dot_product_core.sv
// tb_dequantized_dot_product_core: drives items and register writes into the core,
// with random idling on both channels, and gives the verdict from the checker's count
// depends on dqdp_pkg, dqdp_if, dqdp_checker and the core
module tb_dequantized_dot_product_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 4;
	// the core blocks its input while it finishes an item with last, give it some margin
	localparam int DRAIN_CYCLES = 16;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SEGMENTS = 4;
	localparam int SEGMENT_ITEMS = 28;
	localparam int MAX_LEN = dqdp_pkg::MAX_LEN;
	// index past the last register, writes to it must be dropped
	localparam logic [dqdp_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	bit   rx_hold_req = 1'b0;
	int   idle_cycles = 0;
	int   fail_count;
	int   pending;

	dqdp_in_if  in_ch();
	dqdp_out_if out_ch();
	dqdp_cfg_if cfg_ch();

	dequantized_dot_product_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (in_ch),
		.dout   (out_ch),
		.cfg    (cfg_ch)
	);

	dqdp_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (in_ch),
		.dout       (out_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog: end the run when no channel moves anything for too long
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				// the sender keeps offering items meanwhile, so the core backs up
				for (int n = 0; n < RX_HOLD_CYCLES; n++)
					@(posedge clk);
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// one register write, valid is dropped again before the task returns
	task automatic write_reg(input logic [dqdp_pkg::CFG_IDX_W-1:0] idx,
		input logic [dqdp_pkg::CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// offer one item, with random gaps ahead of it, and wait until it is taken
	task automatic send_item(input logic [dqdp_pkg::CODE_W-1:0] code,
		input logic signed [dqdp_pkg::Q_W-1:0] act, input logic is_last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.weight_code <= code;
		in_ch.activation <= act;
		in_ch.last <= is_last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// registers only change with the core idle: all results in, then a short pause
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// codes lean toward the ends of the range
	function automatic logic [dqdp_pkg::CODE_W-1:0] pick_code();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return dqdp_pkg::CODE_W'($urandom_range(0, 255));
		endcase
	endfunction

	// activations: full scale extremes, small values near zero, or anything
	function automatic logic signed [dqdp_pkg::Q_W-1:0] pick_activation();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2, 3: return dqdp_pkg::Q_W'(int'($urandom_range(0, 511)) - 256);
			default: return dqdp_pkg::Q_W'($urandom);
		endcase
	endfunction

	// mostly short dot products, some medium, a few up to the full length
	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r == 0)
			return MAX_LEN;
		else if (r < 3)
			return $urandom_range(64, MAX_LEN);
		else if (r < 20)
			return $urandom_range(9, 32);
		else
			return $urandom_range(1, 8);
	endfunction

	// a random setting of all three registers, extremes included
	task automatic write_random_config();
		logic [dqdp_pkg::CFG_DATA_W-1:0] scale_val;
		logic [dqdp_pkg::CFG_DATA_W-1:0] offset_val;
		case ($urandom_range(0, 5))
			0: scale_val = '0;
			1: scale_val = '1;
			2, 3: scale_val = dqdp_pkg::CFG_DATA_W'($urandom_range(1, 64));
			default: scale_val = dqdp_pkg::CFG_DATA_W'($urandom_range(0, 65535));
		endcase
		case ($urandom_range(0, 5))
			0: offset_val = 16'h8000;
			1: offset_val = 16'h7fff;
			2, 3: offset_val = dqdp_pkg::CFG_DATA_W'(int'($urandom_range(0, 511)) - 256);
			default: offset_val = dqdp_pkg::CFG_DATA_W'($urandom_range(0, 65535));
		endcase
		write_reg(dqdp_pkg::REG_SCALE, scale_val);
		write_reg(dqdp_pkg::REG_OFFSET, offset_val);
		// upper bits of the mode write are don't-care
		write_reg(dqdp_pkg::REG_MODE, dqdp_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE, dqdp_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
	endtask

	initial begin
		int seg_items;
		int len;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.weight_code <= '0;
		in_ch.activation <= '0;
		in_ch.last <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= dqdp_pkg::REG_SCALE;
		cfg_ch.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers give scale zero, so the entry is zero
		send_item(8'd255, 16'sd32767, 1'b1);
		wait_drained();

		// full scale, most negative offset, mode 0 written with junk above bit 0,
		// and a write past the last register that must change nothing
		write_reg(dqdp_pkg::REG_SCALE, 16'hffff);
		write_reg(dqdp_pkg::REG_OFFSET, 16'h8000);
		write_reg(dqdp_pkg::REG_MODE, 16'h0002);
		write_reg(REG_SPARE, 16'hffff);
		send_item(8'd255, 16'sd32767, 1'b1);   // clips high
		send_item(8'd255, -16'sd32768, 1'b1);  // clips low
		send_item(8'd0, 16'sd32767, 1'b0);
		send_item(8'd0, -16'sd32768, 1'b1);    // lands exactly on the minimum, no clip
		send_item(8'd128, 16'sd0, 1'b1);
		wait_drained();

		// weight-column form, offset at its maximum
		write_reg(dqdp_pkg::REG_SCALE, 16'd16);
		write_reg(dqdp_pkg::REG_OFFSET, 16'h7fff);
		write_reg(dqdp_pkg::REG_MODE, 16'hffff);
		send_item(8'd1, 16'sd4096, 1'b0);
		send_item(8'd2, -16'sd4096, 1'b0);
		send_item(8'd255, 16'sd100, 1'b1);
		send_item(8'd17, -16'sd32768, 1'b0);
		send_item(8'd170, 16'sd32767, 1'b1);
		send_item(8'd0, 16'sd0, 1'b1);
		wait_drained();

		// scale of zero: only the weighted offset term is left
		write_reg(dqdp_pkg::REG_SCALE, 16'd0);
		write_reg(dqdp_pkg::REG_OFFSET, 16'd4096);
		send_item(8'd255, -16'sd32768, 1'b0);
		send_item(8'd255, -16'sd32768, 1'b1);
		send_item(8'd200, 16'sd12345, 1'b1);
		wait_drained();

		// smallest nonzero scale, truncation of the product term
		write_reg(dqdp_pkg::REG_SCALE, 16'd1);
		write_reg(dqdp_pkg::REG_OFFSET, 16'd0);
		write_reg(dqdp_pkg::REG_MODE, 16'd0);
		send_item(8'd255, 16'sd32767, 1'b1);
		send_item(8'd255, -16'sd1, 1'b1);
		wait_drained();

		// one full-length dot product of the largest negative products
		for (int i = 0; i < MAX_LEN; i++)
			send_item(8'd255, -16'sd32768, i == MAX_LEN - 1);
		wait_drained();

		// random part: three idling phases, each with several register settings
		for (int phase = 0; phase < 3; phase++) begin
			unique case (phase)
				0: begin
					tx_idle_pct = 13;
					rx_idle_pct = 51;
				end
				1: begin
					tx_idle_pct = 51;
					rx_idle_pct = 13;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < SEGMENTS; seg++) begin
				write_random_config();
				// in the full-rate phase the result side stalls for a long stretch once
				if (phase == 2 && seg == 1)
					rx_hold_req = 1'b1;
				seg_items = 0;
				while (seg_items < SEGMENT_ITEMS) begin
					len = pick_length();
					// the last dot product of a segment is cut to fit
					if (len > SEGMENT_ITEMS - seg_items)
						len = SEGMENT_ITEMS - seg_items;
					for (int i = 0; i < len; i++)
						send_item(pick_code(), pick_activation(), i == len - 1);
					seg_items += len;
				end
				wait_drained();
			end
		end

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
